/* sv/hfrq_pkg.sv */
package hfrq_pkg;

    // Size of the frame ring and of one frame slot.
    localparam int QUEUE_DEPTH = 4;
    localparam int FRAME_BYTES = 1024;

    // Derived widths.
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int OFF_W  = $clog2(FRAME_BYTES);
    localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTE_W = 8;

    // Fixed byte values of the framing.
    localparam logic [BYTE_W-1:0] ADDR_ALL_STATIONS = 8'hFF;
    localparam logic [BYTE_W-1:0] FLAG_RESET        = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_NONE         = 8'h00;

endpackage

/* sv/hdlc_frame_receiver_queue.sv */
// PPP/HDLC receive frame delimiter feeding a ring of frame slots. Each
// accepted item (one received byte with its byte_valid qualifier and a
// frame_taken pulse from the consumer) yields exactly one result item: a
// slot write command, frame-close status and the queue fill level. An item
// passes an input register and a result register before its result is
// presented, and it is taken at a clock edge when the output side is ready;
// the block takes one item per cycle sustained while the output side is
// ready, with the framing state updated between those two registers.
// Hunting needs the flag byte
// followed directly by 0xFF; the frame then runs to the next flag, and both
// flags are stored. A byte that arrives after a slot is full is dropped,
// the sticky buffer overflow flag is set and the receiver hunts again. The
// flag byte is written through i_cfg_we/i_cfg_data and must only change
// while no item is in flight.
module hdlc_frame_receiver_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: flag byte.
    input  logic                              i_cfg_we,
    input  logic [hfrq_pkg::BYTE_W-1:0]       i_cfg_data,
    // Input channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [hfrq_pkg::BYTE_W-1:0]       i_rx_byte,
    input  logic                              i_byte_valid,
    input  logic                              i_frame_taken,
    // Result channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_store_enable,
    output logic [hfrq_pkg::SLOT_W-1:0]       o_store_slot,
    output logic [hfrq_pkg::OFF_W-1:0]        o_store_offset,
    output logic [hfrq_pkg::BYTE_W-1:0]       o_store_data,
    output logic                              o_frame_done,
    output logic [hfrq_pkg::CNT_W-1:0]        o_frame_length,
    output logic                              o_buffer_overflow,
    output logic                              o_queue_overflow,
    output logic [hfrq_pkg::QCNT_W-1:0]       o_frames_queued
);

    // Configuration register.
    logic [hfrq_pkg::BYTE_W-1:0] r_flag;

    // Input register.
    logic                        r_in_valid;
    logic [hfrq_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_bvalid;
    logic                        r_in_taken;

    // Framing state.
    logic                        r_in_frame,  n_in_frame;
    logic [hfrq_pkg::BYTE_W-1:0] r_prev,      n_prev;
    logic [hfrq_pkg::CNT_W-1:0]  r_count,     n_count;
    logic [hfrq_pkg::SLOT_W-1:0] r_slot,      n_slot;
    logic [hfrq_pkg::QCNT_W-1:0] r_fcount,    n_fcount;
    logic                        r_ovf,       n_ovf;

    // Result register.
    logic                        r_out_valid;
    logic                        r_st_en,     n_st_en;
    logic [hfrq_pkg::SLOT_W-1:0] r_st_slot,   n_st_slot;
    logic [hfrq_pkg::OFF_W-1:0]  r_st_off,    n_st_off;
    logic [hfrq_pkg::BYTE_W-1:0] r_st_data,   n_st_data;
    logic                        r_done,      n_done;
    logic [hfrq_pkg::CNT_W-1:0]  r_flen,      n_flen;
    logic                        r_qovf,      n_qovf;

    // Byte position before the increment that every valid byte gets while the slot has room.
    logic [hfrq_pkg::CNT_W-1:0]  count_base;
    logic                        advance;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        n_in_frame = r_in_frame;
        n_prev     = r_prev;
        n_count    = r_count;
        n_slot     = r_slot;
        n_fcount   = r_fcount;
        n_ovf      = r_ovf;
        n_st_en    = 1'b0;
        n_st_slot  = '0;
        n_st_off   = '0;
        n_st_data  = '0;
        n_done     = 1'b0;
        n_flen     = '0;
        n_qovf     = 1'b0;
        count_base = r_count;

        if (r_in_bvalid) begin
            if (r_count < hfrq_pkg::CNT_W'(hfrq_pkg::FRAME_BYTES)) begin
                if (!r_in_frame) begin
                    if (r_in_byte == r_flag) begin
                        // Opening flag: restart the slot at offset zero.
                        count_base = '0;
                        n_st_en    = 1'b1;
                        n_st_slot  = r_slot;
                        n_st_data  = r_in_byte;
                        n_prev     = r_in_byte;
                    end else if (r_in_byte == hfrq_pkg::ADDR_ALL_STATIONS
                                 && r_prev == r_flag) begin
                        n_in_frame = 1'b1;
                        n_st_en    = 1'b1;
                        n_st_slot  = r_slot;
                        n_st_off   = r_count[hfrq_pkg::OFF_W-1:0];
                        n_st_data  = r_in_byte;
                        n_prev     = r_in_byte;
                    end else begin
                        // Line noise while hunting is not stored.
                        count_base = '0;
                        n_prev     = hfrq_pkg::BYTE_NONE;
                    end
                end else begin
                    n_st_en   = 1'b1;
                    n_st_slot = r_slot;
                    n_st_off  = r_count[hfrq_pkg::OFF_W-1:0];
                    n_st_data = r_in_byte;
                    if (r_in_byte == r_flag) begin
                        // Closing flag: report, move to the next slot and
                        // queue the frame, overwriting the oldest if full.
                        n_done     = 1'b1;
                        n_flen     = r_count + hfrq_pkg::CNT_W'(1);
                        n_in_frame = 1'b0;
                        n_prev     = hfrq_pkg::BYTE_NONE;
                        if (r_slot == hfrq_pkg::SLOT_W'(hfrq_pkg::QUEUE_DEPTH - 1)) begin
                            n_slot = '0;
                        end else begin
                            n_slot = r_slot + hfrq_pkg::SLOT_W'(1);
                        end
                        if (r_fcount == hfrq_pkg::QCNT_W'(hfrq_pkg::QUEUE_DEPTH)) begin
                            n_qovf = 1'b1;
                        end else begin
                            n_fcount = r_fcount + hfrq_pkg::QCNT_W'(1);
                        end
                    end else begin
                        n_prev = r_in_byte;
                    end
                end
                n_count = count_base + hfrq_pkg::CNT_W'(1);
            end else begin
                // Slot already full: drop the byte and hunt again.
                n_ovf      = 1'b1;
                n_in_frame = 1'b0;
                n_prev     = hfrq_pkg::BYTE_NONE;
                n_count    = '0;
            end
        end

        // The consumer's take is applied after the byte.
        if (r_in_taken && n_fcount != '0) begin
            n_fcount = n_fcount - hfrq_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= hfrq_pkg::FLAG_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_frame  <= 1'b0;
            r_prev      <= '0;
            r_count     <= '0;
            r_slot      <= '0;
            r_fcount    <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_flag <= i_cfg_data;
            end
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_in_frame  <= n_in_frame;
                r_prev      <= n_prev;
                r_count     <= n_count;
                r_slot      <= n_slot;
                r_fcount    <= n_fcount;
                r_ovf       <= n_ovf;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte   <= i_rx_byte;
            r_in_bvalid <= i_byte_valid;
            r_in_taken  <= i_frame_taken;
        end
        if (advance) begin
            r_st_en   <= n_st_en;
            r_st_slot <= n_st_slot;
            r_st_off  <= n_st_off;
            r_st_data <= n_st_data;
            r_done    <= n_done;
            r_flen    <= n_flen;
            r_qovf    <= n_qovf;
        end
    end

    // Sticky flag and queue level are shown as of the delivered item.
    logic                        r_out_ovf;
    logic [hfrq_pkg::QCNT_W-1:0] r_out_fcount;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ovf    <= n_ovf;
            r_out_fcount <= n_fcount;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_store_enable    = r_st_en;
    assign o_store_slot      = r_st_slot;
    assign o_store_offset    = r_st_off;
    assign o_store_data      = r_st_data;
    assign o_frame_done      = r_done;
    assign o_frame_length    = r_flen;
    assign o_buffer_overflow = r_out_ovf;
    assign o_queue_overflow  = r_qovf;
    assign o_frames_queued   = r_out_fcount;

endmodule

/* sv/hfrq_checker.sv */
module hfrq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_store_enable,
    input logic [hfrq_pkg::SLOT_W-1:0]       o_store_slot,
    input logic [hfrq_pkg::OFF_W-1:0]        o_store_offset,
    input logic [hfrq_pkg::BYTE_W-1:0]       o_store_data,
    input logic                              o_frame_done,
    input logic [hfrq_pkg::CNT_W-1:0]        o_frame_length,
    input logic                              o_buffer_overflow,
    input logic                              o_queue_overflow
);

    // A closed frame always writes its closing flag and has a length.
    a_done_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_store_enable && o_frame_length != '0)
        else $error("frame close without a store or a length");

    // An item that stores nothing carries an all-zero write command.
    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_store_enable |->
            o_store_slot == '0 && o_store_offset == '0 && o_store_data == '0)
        else $error("write fields set without store enable");

    // Queue overwrite and length are only reported on a frame close.
    a_qovf_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_queue_overflow || o_frame_length != '0) |-> o_frame_done)
        else $error("close status without a frame close");

    // The buffer overflow flag never clears once delivered.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_buffer_overflow |=> o_buffer_overflow)
        else $error("buffer overflow flag cleared");

    // A result item that is not taken stays offered with its data, offset and length unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_store_data)
            && $stable(o_store_offset) && $stable(o_frame_length))
        else $error("result item changed while waiting");

endmodule

bind hdlc_frame_receiver_queue hfrq_checker u_hfrq_checker (.*);

/* dv/tb_hdlc_frame_receiver_queue.sv */
module tb_hdlc_frame_receiver_queue;

    // A run with no handshake on either side for this many cycles is hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_ITEMS   = 40;

    // Receiver stall patterns. The pattern is re-drawn throughout the run so that
    // stalls fall on every phase of the framing, with clean stretches too.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_RARE_STALL,
        READY_EVERY_FOURTH
    } t_ready_mode;

    // One result item as the block presents it.
    typedef struct packed {
        logic                          store_enable;
        logic [hfrq_pkg::SLOT_W-1:0]   store_slot;
        logic [hfrq_pkg::OFF_W-1:0]    store_offset;
        logic [hfrq_pkg::BYTE_W-1:0]   store_data;
        logic                          frame_done;
        logic [hfrq_pkg::CNT_W-1:0]    frame_length;
        logic                          buffer_overflow;
        logic                          queue_overflow;
        logic [hfrq_pkg::QCNT_W-1:0]   frames_queued;
    } t_slot_write;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [hfrq_pkg::BYTE_W-1:0]   i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [hfrq_pkg::BYTE_W-1:0]   i_rx_byte = '0;
    logic                          i_byte_valid = 1'b0;
    logic                          i_frame_taken = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_store_enable;
    logic [hfrq_pkg::SLOT_W-1:0]   o_store_slot;
    logic [hfrq_pkg::OFF_W-1:0]    o_store_offset;
    logic [hfrq_pkg::BYTE_W-1:0]   o_store_data;
    logic                          o_frame_done;
    logic [hfrq_pkg::CNT_W-1:0]    o_frame_length;
    logic                          o_buffer_overflow;
    logic                          o_queue_overflow;
    logic [hfrq_pkg::QCNT_W-1:0]   o_frames_queued;

    hdlc_frame_receiver_queue dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .i_byte_valid      (i_byte_valid),
        .i_frame_taken     (i_frame_taken),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_store_enable    (o_store_enable),
        .o_store_slot      (o_store_slot),
        .o_store_offset    (o_store_offset),
        .o_store_data      (o_store_data),
        .o_frame_done      (o_frame_done),
        .o_frame_length    (o_frame_length),
        .o_buffer_overflow (o_buffer_overflow),
        .o_queue_overflow  (o_queue_overflow),
        .o_frames_queued   (o_frames_queued)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // Shadow copy of the framing state, kept in step with every accepted item.
    logic [hfrq_pkg::BYTE_W-1:0]   rx_flag      = hfrq_pkg::FLAG_RESET;
    logic                          rx_in_frame  = 1'b0;
    logic [hfrq_pkg::BYTE_W-1:0]   rx_last_byte = hfrq_pkg::BYTE_NONE;
    logic [hfrq_pkg::CNT_W-1:0]    rx_fill      = '0;
    logic [hfrq_pkg::SLOT_W-1:0]   rx_slot      = '0;
    logic [hfrq_pkg::QCNT_W-1:0]   rx_queued    = '0;
    logic                          rx_overrun   = 1'b0;

    t_slot_write       pending_writes[$];
    int unsigned       mismatch_count = 0;
    int unsigned       items_sent = 0;
    int unsigned       burst_left = 0;
    int unsigned       hold_off_cycles = 0;
    bit                offering = 1'b0;

    // Works out the result of one accepted item and advances the shadow state.
    function automatic t_slot_write predict_slot_write(
        logic [hfrq_pkg::BYTE_W-1:0] b, logic bv, logic tk);
        t_slot_write r;
        r = '0;
        if (bv) begin
            if (rx_fill < hfrq_pkg::CNT_W'(hfrq_pkg::FRAME_BYTES)) begin
                if (!rx_in_frame) begin
                    if (b == rx_flag) begin
                        // A flag always restarts the hunt at offset zero.
                        rx_fill        = '0;
                        r.store_enable = 1'b1;
                        r.store_slot   = rx_slot;
                        r.store_offset = '0;
                        r.store_data   = b;
                        rx_last_byte   = b;
                    end else if (b == hfrq_pkg::ADDR_ALL_STATIONS
                                 && rx_last_byte == rx_flag) begin
                        rx_in_frame    = 1'b1;
                        r.store_enable = 1'b1;
                        r.store_slot   = rx_slot;
                        r.store_offset = rx_fill[hfrq_pkg::OFF_W-1:0];
                        r.store_data   = b;
                        rx_last_byte   = b;
                    end else begin
                        rx_last_byte = hfrq_pkg::BYTE_NONE;
                        rx_fill      = '0;
                    end
                end else begin
                    r.store_enable = 1'b1;
                    r.store_slot   = rx_slot;
                    r.store_offset = rx_fill[hfrq_pkg::OFF_W-1:0];
                    r.store_data   = b;
                    if (b == rx_flag) begin
                        r.frame_done   = 1'b1;
                        r.frame_length = rx_fill + 1'b1;
                        rx_in_frame    = 1'b0;
                        if (rx_slot == hfrq_pkg::SLOT_W'(hfrq_pkg::QUEUE_DEPTH - 1)) begin
                            rx_slot = '0;
                        end else begin
                            rx_slot = rx_slot + 1'b1;
                        end
                        if (rx_queued == hfrq_pkg::QCNT_W'(hfrq_pkg::QUEUE_DEPTH)) begin
                            r.queue_overflow = 1'b1;
                        end else begin
                            rx_queued = rx_queued + 1'b1;
                        end
                        rx_last_byte = hfrq_pkg::BYTE_NONE;
                    end else begin
                        rx_last_byte = b;
                    end
                end
                rx_fill = rx_fill + 1'b1;
            end else begin
                // Slot is full: the byte is lost and the hunt starts over.
                rx_overrun   = 1'b1;
                rx_in_frame  = 1'b0;
                rx_last_byte = hfrq_pkg::BYTE_NONE;
                rx_fill      = '0;
            end
        end
        if (tk && rx_queued != '0) begin
            rx_queued = rx_queued - 1'b1;
        end
        r.buffer_overflow = rx_overrun;
        r.frames_queued   = rx_queued;
        return r;
    endfunction

    function automatic logic [hfrq_pkg::BYTE_W-1:0] random_byte();
        return hfrq_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [hfrq_pkg::BYTE_W-1:0] payload_byte();
        logic [hfrq_pkg::BYTE_W-1:0] v;
        do begin
            v = random_byte();
        end while (v == rx_flag);
        return v;
    endfunction

    function automatic logic chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // The sender works in bursts; a gap of idle cycles may precede each burst.
    task automatic send_item(logic [hfrq_pkg::BYTE_W-1:0] b, logic bv, logic tk);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                stop_offering();
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_byte_valid  <= bv;
        i_frame_taken <= tk;
        offering = 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        pending_writes.push_back(predict_slot_write(b, bv, tk));
        items_sent++;
        burst_left--;
    endtask

    task automatic stop_offering();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // The sender rests until every result of the items sent so far has come.
    task automatic drain_results();
        stop_offering();
        burst_left = 0;
        do begin
            @(posedge i_clk);
        end while (pending_writes.size() != 0);
    endtask

    task automatic write_flag(logic [hfrq_pkg::BYTE_W-1:0] value);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rx_flag = value;
    endtask

    // Opening flag, address byte, payload and, if asked, the closing flag.
    // Holes are items with byte_valid low scattered through the frame.
    task automatic send_frame(int unsigned payload_len, int unsigned take_pct,
                              int unsigned hole_pct, bit close);
        send_item(rx_flag, 1'b1, chance(take_pct));
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, chance(take_pct));
        for (int unsigned k = 0; k < payload_len; k++) begin
            if (chance(hole_pct)) begin
                send_item(random_byte(), 1'b0, chance(take_pct));
            end
            send_item(payload_byte(), 1'b1, chance(take_pct));
        end
        if (close) begin
            send_item(rx_flag, 1'b1, chance(take_pct));
        end
    endtask

    // Hand-picked byte sequences around the hunt and the frame boundaries.
    task automatic test_framing_basics();
        // Shortest frame with data extremes inside: 0x00 and 0xFF are data.
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        send_item(hfrq_pkg::BYTE_NONE, 1'b1, 1'b0);
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        // A closing flag does not open the next frame, so this 0xFF is dropped.
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        // Back-to-back flags, the address byte, then a byte that is not valid, then the close.
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        // Garbage while hunting, a flag followed by the wrong byte.
        send_item(8'h12, 1'b1, 1'b0);
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        // Two takes empty the queue, the third finds nothing to free.
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        // A take on the same item as the closing flag.
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b1);
    endtask

    // More closes than slots without any take: slot wrap and queue overflow.
    task automatic test_queue_wrap();
        for (int k = 0; k < hfrq_pkg::QUEUE_DEPTH + 2; k++) begin
            send_frame(k % 2, 0, 0, 1'b1);
        end
        for (int k = 0; k < hfrq_pkg::QUEUE_DEPTH + 1; k++) begin
            send_item(random_byte(), 1'b0, 1'b1);
        end
    endtask

    // Flag register at its extremes. With 0xFF as flag no frame can open.
    task automatic test_flag_register();
        write_flag(8'h00);
        send_frame(3, 0, 0, 1'b1);
        send_item(hfrq_pkg::FLAG_RESET, 1'b1, 1'b0);
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        write_flag(8'hFF);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h10, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        write_flag(hfrq_pkg::FLAG_RESET);
    endtask

    // Mostly well-formed frames with random content, with noise, broken
    // sequences and idle items mixed in. Four flag settings, each with its own
    // take rate so the queue both fills up and runs dry.
    task automatic test_random_traffic();
        logic [hfrq_pkg::BYTE_W-1:0] flags[4];
        int unsigned                 take_rates[4];
        int unsigned                 phase_start;
        int unsigned                 pick;
        flags      = '{hfrq_pkg::FLAG_RESET, 8'h00, 8'hAA, 8'h55};
        take_rates = '{5, 20, 40, 12};
        foreach (flags[p]) begin
            write_flag(flags[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame(chance(3) ? $urandom_range(100, 300) : $urandom_range(0, 24),
                               take_rates[p], 8, 1'b1);
                end else if (pick < 80) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(random_byte(), 1'($urandom_range(0, 1)),
                                  chance(take_rates[p]));
                    end
                end else if (pick < 90) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            send_item(rx_flag, 1'b1, 1'b0);
                            send_item(payload_byte(), 1'b1, chance(take_rates[p]));
                        end
                        1: send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1,
                                     chance(take_rates[p]));
                        default: send_frame($urandom_range(0, 6), take_rates[p], 0, 1'b0);
                    endcase
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(random_byte(), 1'b0, chance(take_rates[p]));
                    end
                end
            end
        end
        write_flag(hfrq_pkg::FLAG_RESET);
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input while the sender keeps offering; then the sender waits for the
    // block to empty before traffic resumes.
    task automatic test_backpressure();
        hold_off_cycles = HOLD_OFF_LEN;
        for (int k = 0; k < 4; k++) begin
            send_frame(20, 10, 5, 1'b1);
        end
        drain_results();
        for (int k = 0; k < 3; k++) begin
            send_frame($urandom_range(0, 12), 50, 5, 1'b1);
        end
    endtask

    // A frame that fills the slot exactly leaves no room, so the next byte,
    // even a flag, is dropped and raises the sticky overflow flag; the
    // receiver then hunts again. The flag is sticky, so this comes last.
    task automatic test_slot_limits();
        send_frame(hfrq_pkg::FRAME_BYTES - 3, 0, 0, 1'b1);
        send_item(rx_flag, 1'b1, 1'b0);
        send_item(hfrq_pkg::ADDR_ALL_STATIONS, 1'b1, 1'b0);
        send_frame(4, 30, 0, 1'b1);
    endtask

    // Receiver side: a forced hold-off when one is asked for, otherwise a
    // stall pattern that is re-drawn throughout the run.
    initial begin
        t_ready_mode mode;
        int unsigned tick;
        mode = READY_ALWAYS;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (tick % 64 == 0) begin
                mode = t_ready_mode'($urandom_range(0, 3));
            end
            if (hold_off_cycles != 0) begin
                i_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                case (mode)
                    READY_ALWAYS:     i_ready <= 1'b1;
                    READY_COIN:       i_ready <= 1'($urandom_range(0, 1));
                    READY_RARE_STALL: i_ready <= ($urandom_range(0, 9) != 0);
                    default:          i_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%s mismatch: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    // Every accepted result is matched against the oldest prediction.
    initial begin
        t_slot_write want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
                if (pending_writes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result item arrived with none outstanding");
                    end
                end else begin
                    want = pending_writes.pop_front();
                    check_field("store_enable", want.store_enable, o_store_enable);
                    check_field("store_slot", want.store_slot, o_store_slot);
                    check_field("store_offset", want.store_offset, o_store_offset);
                    check_field("store_data", want.store_data, o_store_data);
                    check_field("frame_done", want.frame_done, o_frame_done);
                    check_field("frame_length", want.frame_length, o_frame_length);
                    check_field("buffer_overflow", want.buffer_overflow, o_buffer_overflow);
                    check_field("queue_overflow", want.queue_overflow, o_queue_overflow);
                    check_field("frames_queued", want.frames_queued, o_frames_queued);
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved an item for too
    // long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1)
                || i_rst_n !== 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_hdlc_frame_receiver_queue failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_framing_basics();
        test_queue_wrap();
        test_flag_register();
        test_random_traffic();
        test_backpressure();
        test_slot_limits();
        drain_results();
        // More idle clocks so that a stray extra result would still be seen.
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_hdlc_frame_receiver_queue passed");
        end else begin
            $display("tb_hdlc_frame_receiver_queue failed");
        end
        $finish;
    end

endmodule
